// ===== rtl/astar_pkg.sv =====
// Shared types, constants and helpers for the A* graph path search block.
package astar_pkg;

  localparam int DEF_NUM_NODES  = 64;
  localparam int DEF_MAX_DEGREE = 8;

  localparam int CMD_W   = 2;
  localparam int NODE_W  = 6;
  localparam int COORD_W = 16;
  localparam int DEG_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int COST_W  = 32;
  localparam int MAX_OUT = 64;

  // cut-off 1000000.0 in units of 1/16
  localparam logic [COST_W-1:0] COST_CUT = 32'd16000000;

  // distance: floor(sqrt((dx^2 + dy^2) << 8)), operand below 2^41
  localparam int SQ_IN_W  = 42;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int DIST_W   = SQ_STEPS + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD_NODE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_NBR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 2'd2;

  typedef enum logic [2:0] {
    XY_GOAL,
    XY_START,
    XY_BEST,
    XY_NB,
    XY_PATH
  } xy_sel_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIFF,
    SQ_MUL,
    SQ_SUM,
    SQ_ITER
  } sq_phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_GOAL,
    S_RD_START,
    S_SQ0,
    S_SQ0_W,
    S_SCAN,
    S_PICK,
    S_CUR,
    S_NB_RD,
    S_NB_CHK,
    S_NB_SQ,
    S_D1,
    S_D2,
    S_UPD,
    S_TR_CHK,
    S_TR_WR,
    S_EM_RD,
    S_EM_XY,
    S_EM_OUT,
    S_FAIL
  } state_t;

  typedef struct packed {
    logic    in_take;
    logic    search_start;
    logic    cap_goal;
    logic    cap_cur;
    logic    init_write;
    logic    scan_start;
    logic    scan_run;
    logic    pick;
    logic    rd_best;
    logic    xy_rd;
    xy_sel_t xy_sel;
    logic    f_rd_nb;
    logic    nb_rd;
    logic    k_inc;
    logic    sq_start;
    logic    sq_b_cur;
    logic    cap_g;
    logic    cap_f;
    logic    upd;
    logic    tr_rd;
    logic    tr_step;
    logic    em_start;
    logic    em_rd;
    logic    em_dec;
    logic    out_path;
    logic    out_fail;
  } dp_cmd_t;

  typedef struct packed {
    logic ends_ok;
    logic scan_done;
    logic best_any;
    logic best_goal;
    logic k_end;
    logic iter_end;
    logic nb_skip;
    logic sq_busy;
    logic sq_done;
    logic tr_end;
    logic em_zero;
    logic out_free;
  } dp_sts_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? '1 : s[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/astar_graph_path_search.sv =====
// A* path search over a stored graph: top level joining controller and datapath.
// Load items (node coordinates/degree, one neighbor slot) are taken one per cycle and
// give no result. A search item runs A* from start to goal and then emits the path
// start to goal, one transaction per node, last set on the final one; a failed search
// emits a single transaction with found clear. Search time is set by the expansion
// loop: each expansion scans the cost memory once, and each neighbor not yet closed
// costs two evaluations of the distance unit, each running a 21-step square root.
// Emitting a path node reads the path buffer, then its coordinates, then loads the
// output register once it is free. A new item is accepted only between searches; a
// waiting result does not block loads.
module astar_graph_path_search import astar_pkg::*; #(
  parameter int NUM_NODES  = DEF_NUM_NODES,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          command,
  input  logic [NODE_W-1:0]         node,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic [DEG_W-1:0]          degree,
  input  logic [SLOT_W-1:0]         slot,
  input  logic [NODE_W-1:0]         other_node,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      found,
  output logic [NODE_W-1:0]         path_node,
  output logic signed [COORD_W-1:0] path_x,
  output logic signed [COORD_W-1:0] path_y,
  output logic                      last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  astar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  astar_dp #(
    .NUM_NODES  (NUM_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .command    (command),
    .node       (node),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .degree     (degree),
    .slot       (slot),
    .other_node (other_node),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .path_node  (path_node),
    .path_x     (path_x),
    .path_y     (path_y),
    .last       (last)
  );

`ifndef SYNTHESIS
  // a result is loaded only when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_path || cmd.out_fail) |-> sts.out_free)
    else $error("result loaded over a pending transaction");

  // the distance unit is never restarted mid-evaluation
  a_sq_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.sq_start |-> !sts.sq_busy)
    else $error("distance unit started while busy");

  // a search starts only from an accepted input transaction
  a_search_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.search_start |-> (in_valid && in_ready))
    else $error("search started without an accepted transaction");

  // no input is taken while a search is running
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (sts.sq_busy || cmd.scan_run) |-> !in_ready)
    else $error("input ready during a search");
`endif

endmodule

// ===== rtl/astar_dist.sv =====
// Euclidean distance unit: differences, squares, then a bit-serial square root.
module astar_dist import astar_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  output logic                      busy,
  output logic                      done,
  output logic [DIST_W-1:0]         dist_val
);

  sq_phase_t phase;
  logic signed [COORD_W:0]  dx, dy;
  logic [COORD_W-1:0]       ux, uy;
  logic [2*COORD_W-1:0]     sqx, sqy;
  logic [SQ_IN_W-1:0]       rem, root, bitv;
  logic [$clog2(SQ_STEPS)-1:0] cnt;
  logic [SQ_IN_W-1:0]       trial;

  assign trial    = root + bitv;
  assign busy     = (phase != SQ_IDLE);
  assign dist_val = root[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SQ_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        SQ_IDLE: if (start) phase <= SQ_DIFF;
        SQ_DIFF: phase <= SQ_MUL;
        SQ_MUL:  phase <= SQ_SUM;
        SQ_SUM:  phase <= SQ_ITER;
        SQ_ITER: begin
          if (cnt == ($clog2(SQ_STEPS))'(SQ_STEPS - 1)) begin
            phase <= SQ_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= SQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      SQ_IDLE: begin
        dx <= (COORD_W+1)'(ax) - (COORD_W+1)'(bx);
        dy <= (COORD_W+1)'(ay) - (COORD_W+1)'(by);
      end
      SQ_DIFF: begin
        ux <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        uy <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      end
      SQ_MUL: begin
        sqx <= ux * ux;
        sqy <= uy * uy;
      end
      SQ_SUM: begin
        rem  <= SQ_IN_W'({(2*COORD_W+1)'(sqx) + (2*COORD_W+1)'(sqy), 8'd0});
        root <= '0;
        bitv <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        cnt  <= '0;
      end
      SQ_ITER: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/astar_dp.sv =====
// Datapath: graph tables, search scratch memories, open/closed sets and result register.
module astar_dp import astar_pkg::*; #(
  parameter int NUM_NODES  = DEF_NUM_NODES,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  input  logic [CMD_W-1:0]          command,
  input  logic [NODE_W-1:0]         node,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic [DEG_W-1:0]          degree,
  input  logic [SLOT_W-1:0]         slot,
  input  logic [NODE_W-1:0]         other_node,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      found,
  output logic [NODE_W-1:0]         path_node,
  output logic signed [COORD_W-1:0] path_x,
  output logic signed [COORD_W-1:0] path_y,
  output logic                      last
);

  localparam int NW      = $clog2(NUM_NODES);
  localparam int CW      = NW + 1;
  localparam int DGW     = $clog2(MAX_DEGREE + 1);
  localparam int AW      = $clog2(NUM_NODES * MAX_DEGREE);
  localparam int OUT_LIM = (NUM_NODES < MAX_OUT) ? NUM_NODES : MAX_OUT;

  logic [COORD_W-1:0] x_mem [NUM_NODES];
  logic [COORD_W-1:0] y_mem [NUM_NODES];
  logic [DGW-1:0]     deg_mem [NUM_NODES];
  logic [NODE_W-1:0]  nbr_mem [NUM_NODES*MAX_DEGREE];
  logic [COST_W-1:0]  g_mem [NUM_NODES];
  logic [COST_W-1:0]  f_mem [NUM_NODES];
  logic [NW-1:0]      cf_mem [NUM_NODES];
  logic [NW-1:0]      pb_mem [NUM_NODES];
  logic [NUM_NODES-1:0] deg_vld;

  logic [COORD_W-1:0] x_rd, y_rd;
  logic [DGW-1:0]     deg_rd;
  logic [NODE_W-1:0]  nb_rd;
  logic [COST_W-1:0]  g_rd, f_rd;
  logic [NW-1:0]      cf_rd, pb_rd;

  logic [NW-1:0]      start_idx, goal_idx, best_idx;
  logic               ends_ok;
  logic [COORD_W-1:0] goal_x, goal_y, cur_x, cur_y;
  logic [DGW-1:0]     k;
  logic [CW-1:0]      sc, iter, tr_cnt;
  logic               cmp_v, best_any;
  logic [NW-1:0]      cmp_idx, tr_n, em;
  logic [COST_W-1:0]  best, g_new, f_new;
  logic [NUM_NODES-1:0] open_f, closed_f;

  logic               ld_ok, slot_ok, nb_ok, scan_more, f_rd_en, do_upd;
  logic [NW-1:0]      ld_idx, nb_idx, xy_addr, f_addr;
  logic [AW-1:0]      ld_nbr_addr, rd_nbr_addr;
  logic               sq_busy, sq_done;
  logic [DIST_W-1:0]  sq_dist;
  logic [COST_W-1:0]  dist32;

  assign ld_ok       = 32'(node) < NUM_NODES;
  assign slot_ok     = 32'(slot) < MAX_DEGREE;
  assign ld_idx      = NW'(node);
  assign ld_nbr_addr = AW'(32'(ld_idx) * MAX_DEGREE + 32'(slot));
  assign rd_nbr_addr = AW'(32'(best_idx) * MAX_DEGREE + 32'(k));
  assign nb_ok       = 32'(nb_rd) < NUM_NODES;
  assign nb_idx      = NW'(nb_rd);
  assign scan_more   = sc < CW'(NUM_NODES);
  assign f_rd_en     = (cmd.scan_run && scan_more) || cmd.f_rd_nb;
  assign f_addr      = cmd.f_rd_nb ? nb_idx : sc[NW-1:0];
  assign dist32      = COST_W'(sq_dist);
  assign do_upd      = !open_f[nb_idx] || (f_new < f_rd);

  always_comb begin
    unique case (cmd.xy_sel)
      XY_GOAL:  xy_addr = goal_idx;
      XY_START: xy_addr = start_idx;
      XY_BEST:  xy_addr = best_idx;
      XY_NB:    xy_addr = nb_idx;
      XY_PATH:  xy_addr = pb_rd;
      default:  xy_addr = goal_idx;
    endcase
  end

  astar_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sq_start),
    .ax       (x_rd),
    .ay       (y_rd),
    .bx       (cmd.sq_b_cur ? cur_x : goal_x),
    .by       (cmd.sq_b_cur ? cur_y : goal_y),
    .busy     (sq_busy),
    .done     (sq_done),
    .dist_val (sq_dist)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.in_take && command == CMD_LOAD_NODE && ld_ok) begin
      x_mem[ld_idx]   <= x_coord;
      y_mem[ld_idx]   <= y_coord;
      deg_mem[ld_idx] <= (32'(degree) > MAX_DEGREE) ? DGW'(MAX_DEGREE) : DGW'(degree);
    end
    if (cmd.in_take && command == CMD_LOAD_NBR && ld_ok && slot_ok) begin
      nbr_mem[ld_nbr_addr] <= other_node;
    end
    if (cmd.xy_rd) begin
      x_rd <= x_mem[xy_addr];
      y_rd <= y_mem[xy_addr];
    end
    if (cmd.rd_best) begin
      g_rd   <= g_mem[best_idx];
      deg_rd <= deg_vld[best_idx] ? deg_mem[best_idx] : '0;
    end
    if (cmd.nb_rd) nb_rd <= nbr_mem[rd_nbr_addr];
    if (f_rd_en) f_rd <= f_mem[f_addr];
    if (cmd.tr_rd) cf_rd <= cf_mem[tr_n];
    if (cmd.em_rd) pb_rd <= pb_mem[em];

    if (cmd.init_write) begin
      g_mem[start_idx]  <= '0;
      f_mem[start_idx]  <= dist32;
      cf_mem[start_idx] <= start_idx;
    end else if (cmd.upd && do_upd) begin
      g_mem[nb_idx]  <= g_new;
      f_mem[nb_idx]  <= f_new;
      cf_mem[nb_idx] <= best_idx;
    end

    if (cmd.pick && best_idx == goal_idx) begin
      pb_mem[0] <= goal_idx;
    end else if (cmd.tr_step) begin
      pb_mem[tr_cnt[NW-1:0]] <= cf_rd;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      start_idx <= NW'(node);
      goal_idx  <= NW'(other_node);
      ends_ok   <= (32'(node) < NUM_NODES) && (32'(other_node) < NUM_NODES);
    end
    if (cmd.cap_goal) begin
      goal_x <= x_rd;
      goal_y <= y_rd;
    end
    if (cmd.cap_cur) begin
      cur_x <= x_rd;
      cur_y <= y_rd;
    end
    if (cmd.cap_g) g_new <= sat_add(g_rd, dist32);
    if (cmd.cap_f) f_new <= sat_add(g_new, dist32);
    if (cmd.scan_run && cmp_v && open_f[cmp_idx] && f_rd < best) begin
      best     <= f_rd;
      best_idx <= cmp_idx;
    end
    if (cmd.scan_start) best <= COST_CUT;
    if (cmd.scan_run) cmp_idx <= sc[NW-1:0];
    if (cmd.pick) begin
      tr_n <= goal_idx;
    end else if (cmd.tr_step) begin
      tr_n <= cf_rd;
    end
    if (cmd.em_start) begin
      em <= (tr_cnt > CW'(OUT_LIM)) ? NW'(OUT_LIM - 1) : NW'(tr_cnt - CW'(1));
    end else if (cmd.em_dec) begin
      em <= em - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_vld   <= '0;
      open_f    <= '0;
      closed_f  <= '0;
      sc        <= '0;
      cmp_v     <= 1'b0;
      best_any  <= 1'b0;
      iter      <= '0;
      k         <= '0;
      tr_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.in_take && command == CMD_LOAD_NODE && ld_ok) deg_vld[ld_idx] <= 1'b1;
      if (cmd.search_start) begin
        open_f   <= '0;
        closed_f <= '0;
        iter     <= '0;
      end
      if (cmd.init_write) open_f[start_idx] <= 1'b1;
      if (cmd.scan_start) begin
        sc       <= '0;
        cmp_v    <= 1'b0;
        best_any <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_v <= scan_more;
        if (scan_more) sc <= sc + 1'b1;
        if (cmp_v && open_f[cmp_idx] && f_rd < best) best_any <= 1'b1;
      end
      if (cmd.pick) begin
        open_f[best_idx]   <= 1'b0;
        closed_f[best_idx] <= 1'b1;
        iter               <= iter + 1'b1;
        tr_cnt             <= CW'(1);
      end else if (cmd.tr_step) begin
        tr_cnt <= tr_cnt + 1'b1;
      end
      if (cmd.cap_cur) k <= '0;
      else if (cmd.k_inc) k <= k + 1'b1;
      if (cmd.upd && do_upd) open_f[nb_idx] <= 1'b1;
      if (cmd.out_path || cmd.out_fail) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_path) begin
      found     <= 1'b1;
      path_node <= NODE_W'(pb_rd);
      path_x    <= x_rd;
      path_y    <= y_rd;
      last      <= (em == '0);
    end else if (cmd.out_fail) begin
      found     <= 1'b0;
      path_node <= '0;
      path_x    <= '0;
      path_y    <= '0;
      last      <= 1'b1;
    end
  end

  always_comb begin
    sts.ends_ok   = ends_ok;
    sts.scan_done = !scan_more && !cmp_v;
    sts.best_any  = best_any;
    sts.best_goal = (best_idx == goal_idx);
    sts.k_end     = (k == deg_rd);
    sts.iter_end  = (iter == CW'(NUM_NODES));
    sts.nb_skip   = !nb_ok || closed_f[nb_idx];
    sts.sq_busy   = sq_busy;
    sts.sq_done   = sq_done;
    sts.tr_end    = (tr_n == start_idx) || (tr_cnt == CW'(NUM_NODES));
    sts.em_zero   = (em == '0);
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== rtl/astar_ctrl.sv =====
// Controller: sequences loads, the A* expansion loop, path trace and result emission.
module astar_ctrl import astar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  output logic             in_ready,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.xy_sel = XY_GOAL;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
        if (in_valid && command == CMD_SEARCH) begin
          cmd.search_start = 1'b1;
          state_next       = S_RD_GOAL;
        end
      end
      S_RD_GOAL: begin
        if (!sts.ends_ok) begin
          state_next = S_FAIL;
        end else begin
          cmd.xy_rd  = 1'b1;
          cmd.xy_sel = XY_GOAL;
          state_next = S_RD_START;
        end
      end
      S_RD_START: begin
        cmd.cap_goal = 1'b1;
        cmd.xy_rd    = 1'b1;
        cmd.xy_sel   = XY_START;
        state_next   = S_SQ0;
      end
      S_SQ0: begin
        cmd.sq_start = 1'b1;
        state_next   = S_SQ0_W;
      end
      S_SQ0_W: begin
        if (sts.sq_done) begin
          cmd.init_write = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_PICK;
      end
      S_PICK: begin
        if (!sts.best_any) begin
          state_next = S_FAIL;
        end else begin
          cmd.pick = 1'b1;
          if (sts.best_goal) begin
            state_next = S_TR_CHK;
          end else begin
            cmd.rd_best = 1'b1;
            cmd.xy_rd   = 1'b1;
            cmd.xy_sel  = XY_BEST;
            state_next  = S_CUR;
          end
        end
      end
      S_CUR: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_NB_RD;
      end
      S_NB_RD: begin
        if (sts.k_end) begin
          if (sts.iter_end) begin
            state_next = S_FAIL;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else begin
          cmd.nb_rd  = 1'b1;
          state_next = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        if (sts.nb_skip) begin
          cmd.k_inc  = 1'b1;
          state_next = S_NB_RD;
        end else begin
          cmd.xy_rd   = 1'b1;
          cmd.xy_sel  = XY_NB;
          cmd.f_rd_nb = 1'b1;
          state_next  = S_NB_SQ;
        end
      end
      S_NB_SQ: begin
        cmd.sq_start = 1'b1;
        cmd.sq_b_cur = 1'b1;
        state_next   = S_D1;
      end
      S_D1: begin
        if (sts.sq_done) begin
          cmd.cap_g    = 1'b1;
          cmd.sq_start = 1'b1;
          state_next   = S_D2;
        end
      end
      S_D2: begin
        if (sts.sq_done) begin
          cmd.cap_f  = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        cmd.k_inc  = 1'b1;
        state_next = S_NB_RD;
      end
      S_TR_CHK: begin
        if (sts.tr_end) begin
          cmd.em_start = 1'b1;
          state_next   = S_EM_RD;
        end else begin
          cmd.tr_rd  = 1'b1;
          state_next = S_TR_WR;
        end
      end
      S_TR_WR: begin
        cmd.tr_step = 1'b1;
        state_next  = S_TR_CHK;
      end
      S_EM_RD: begin
        cmd.em_rd  = 1'b1;
        state_next = S_EM_XY;
      end
      S_EM_XY: begin
        cmd.xy_rd  = 1'b1;
        cmd.xy_sel = XY_PATH;
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.out_path = 1'b1;
          if (sts.em_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.em_dec = 1'b1;
            state_next = S_EM_RD;
          end
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.out_fail = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
